@@ src/bsm_pkg.sv @@
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types and codes for the bank switch mapper with scanline IRQ.
// ----------------------------------------------------------------------------
package bsm_pkg;

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_CLOCK = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      REG_NONE    = 3'd0,
      REG_CHR_ROM = 3'd1,
      REG_CHR_RAM = 3'd2,
      REG_PRG_RAM = 3'd3,
      REG_PRG_ROM = 3'd4
   } region_type;

   localparam logic [1:0] CSR_PRG_COUNT = 2'd0;
   localparam logic [1:0] CSR_CHR_COUNT = 2'd1;
   localparam logic [1:0] CSR_MIR_FIXED = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] addr;
      logic [7:0]  data;
   } req_type;

   typedef struct packed {
      logic [2:0]  region;
      logic [18:0] rom_address;
      logic [7:0]  read_data;
      logic        mirroring;
      logic        irq_line;
      logic        irq_raised;
   } rsp_type;

   // classified operation handed from the front end to the back end
   typedef struct packed {
      logic        ram_rd;
      logic        ram_wr;
      logic        chr_ram;
      logic [14:0] ram_index;
      logic [7:0]  data;
      logic [2:0]  region;
      logic [18:0] rom_address;
      logic        mirroring;
      logic        irq_line;
      logic        irq_raised;
   } op_type;

endpackage

@@ src/bsm_front.sv @@
// ----------------------------------------------------------------------------
// bsm_front
// Mapper registers, IRQ counter and address translation, one item a cycle.
// ----------------------------------------------------------------------------
module bsm_front import bsm_pkg::*; #(
   parameter int WORK_RAM_BYTES    = 8192,
   parameter int PATTERN_RAM_BYTES = 8192
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  req_type    in_req,
   input  logic       cfg_we,
   input  logic [1:0] cfg_index,
   input  logic [8:0] cfg_data,
   output op_type     op
);

   localparam int WAW = $clog2(WORK_RAM_BYTES);
   localparam int PAW = $clog2(PATTERN_RAM_BYTES);

   logic [6:0] prg_count_ff;
   logic [8:0] chr_count_ff;
   logic       mir_fixed_ff;
   logic [2:0] select_ff;
   logic       prg_mode_ff, chr_inv_ff, mirror_ff;
   logic [7:0] chr_bank_ff [6];
   logic [5:0] prg_bank_ff [2];
   logic [7:0] irq_latch_ff, irq_count_ff;
   logic       irq_enable_ff, irq_pending_ff;

   logic [15:0] a;
   logic [7:0]  d;
   logic        odd;
   logic [2:0]  slot;
   logic [8:0]  cbank;
   logic [7:0]  cmask;
   logic [5:0]  pmask, psecond, pbank;
   logic [1:0]  pslot;
   logic [7:0]  irq_count_in;
   logic        irq_pending_in, raised;
   logic        is_rd, is_wr, is_clk;
   region_type  region;
   logic [18:0] rom_addr;
   logic [14:0] ram_idx;
   logic [18:0] chr_lin;
   logic [15:0] wofs;

   assign a      = in_req.addr;
   assign d      = in_req.data;
   assign odd    = a[0];
   assign is_rd  = in_req.action == ACT_READ;
   assign is_wr  = in_req.action == ACT_WRITE;
   assign is_clk = in_req.action == ACT_CLOCK;

   always_comb begin
      slot = a[12:10] ^ {chr_inv_ff, 2'b00};
      if (!slot[2]) begin
         cbank = {1'b0, chr_bank_ff[{2'b00, slot[1]}]} + {8'd0, slot[0]};
      end else begin
         cbank = {1'b0, chr_bank_ff[slot - 3'd2]};
      end
      cmask   = 8'(chr_count_ff - 9'd1);
      pmask   = 6'(prg_count_ff - 7'd1);
      psecond = 6'(prg_count_ff - 7'd2);
      pslot   = a[14:13];
      unique case (pslot)
         2'd0:    pbank = prg_mode_ff ? psecond : prg_bank_ff[0];
         2'd1:    pbank = prg_bank_ff[1];
         2'd2:    pbank = prg_mode_ff ? prg_bank_ff[0] : psecond;
         default: pbank = pmask;
      endcase
      chr_lin  = {cbank, a[9:0]};
      wofs     = a - 16'h6000;
      region   = REG_NONE;
      rom_addr = '0;
      ram_idx  = '0;
      if (a < 16'h2000) begin
         if (chr_count_ff != 9'd0) begin
            region   = REG_CHR_ROM;
            rom_addr = {1'b0, cbank[7:0] & cmask, a[9:0]};
         end else begin
            region   = REG_CHR_RAM;
            ram_idx  = 15'(chr_lin[PAW-1:0]);
            rom_addr = 19'(chr_lin[PAW-1:0]);
         end
      end else if (a >= 16'h6000 && a < 16'h8000) begin
         region   = REG_PRG_RAM;
         ram_idx  = 15'(wofs[WAW-1:0]);
         rom_addr = 19'(wofs[WAW-1:0]);
      end else if (a >= 16'h8000) begin
         region   = REG_PRG_ROM;
         rom_addr = {pbank & pmask, a[12:0]};
      end
   end

   always_comb begin
      irq_count_in   = irq_count_ff;
      irq_pending_in = irq_pending_ff;
      raised         = 1'b0;
      if (in_valid && is_clk) begin
         irq_count_in = (irq_count_ff == 8'd0) ? irq_latch_ff : irq_count_ff - 8'd1;
         if (irq_count_in == 8'd0 && irq_enable_ff) begin
            irq_pending_in = 1'b1;
            raised         = 1'b1;
         end
      end else if (in_valid && is_wr && region == REG_PRG_ROM) begin
         if (a >= 16'hC000 && a < 16'hE000 && odd) irq_count_in = 8'd0;
         if (a >= 16'hE000 && !odd) irq_pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_count_ff   <= 7'd64;
         chr_count_ff   <= 9'd0;
         mir_fixed_ff   <= 1'b0;
         select_ff      <= '0;
         prg_mode_ff    <= 1'b0;
         chr_inv_ff     <= 1'b0;
         mirror_ff      <= 1'b0;
         chr_bank_ff    <= '{default: '0};
         prg_bank_ff    <= '{default: '0};
         irq_latch_ff   <= '0;
         irq_count_ff   <= '0;
         irq_enable_ff  <= 1'b0;
         irq_pending_ff <= 1'b0;
      end else begin
         if (cfg_we) begin
            if (cfg_index == CSR_PRG_COUNT) prg_count_ff <= cfg_data[6:0];
            if (cfg_index == CSR_CHR_COUNT) chr_count_ff <= cfg_data;
            if (cfg_index == CSR_MIR_FIXED) mir_fixed_ff <= cfg_data[0];
         end
         irq_count_ff   <= irq_count_in;
         irq_pending_ff <= irq_pending_in;
         if (in_valid && is_wr && region == REG_PRG_ROM) begin
            if (a < 16'hA000) begin
               if (!odd) begin
                  select_ff   <= d[2:0];
                  prg_mode_ff <= d[6];
                  chr_inv_ff  <= d[7];
               end else if (select_ff < 3'd2) begin
                  chr_bank_ff[select_ff] <= d & 8'hFE;
               end else if (select_ff < 3'd6) begin
                  chr_bank_ff[select_ff] <= d;
               end else begin
                  prg_bank_ff[select_ff[0]] <= d[5:0];
               end
            end else if (a < 16'hC000) begin
               if (!odd && !mir_fixed_ff) mirror_ff <= d[0];
            end else if (a < 16'hE000) begin
               if (!odd) irq_latch_ff <= d;
            end else begin
               irq_enable_ff <= odd;
            end
         end
      end
   end

   always_comb begin
      op             = '0;
      op.ram_rd      = in_valid && is_rd &&
                       (region == REG_CHR_RAM || region == REG_PRG_RAM);
      op.ram_wr      = in_valid && is_wr &&
                       (region == REG_CHR_RAM || region == REG_PRG_RAM);
      op.chr_ram     = region == REG_CHR_RAM;
      op.ram_index   = ram_idx;
      op.data        = d;
      if (is_rd || is_wr) begin
         op.region      = region;
         op.rom_address = rom_addr;
      end
      // mirroring and irq reflect the state after this transaction
      op.mirroring   = (in_valid && is_wr && region == REG_PRG_ROM && a >= 16'hA000 &&
                        a < 16'hC000 && !odd && !mir_fixed_ff) ? d[0] : mirror_ff;
      op.irq_line    = irq_pending_in;
      op.irq_raised  = raised;
   end

   a_raise_sets_line: assert property (@(posedge clock) disable iff (reset)
      raised |=> irq_pending_ff)
      else $error("irq raised without pending");
   a_raise_needs_enable: assert property (@(posedge clock) disable iff (reset)
      raised |-> irq_enable_ff)
      else $error("irq raised while disabled");
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(in_valid) && !$past(reset) |-> $stable(irq_count_ff))
      else $error("irq count moved with no transaction");

endmodule

@@ src/bsm_back.sv @@
// ----------------------------------------------------------------------------
// bsm_back
// Internal PRG-RAM and CHR-RAM access stage with the result queue.
// ----------------------------------------------------------------------------
module bsm_back import bsm_pkg::*; #(
   parameter int WORK_RAM_BYTES    = 8192,
   parameter int PATTERN_RAM_BYTES = 8192
) (
   input  logic    clock,
   input  logic    reset,
   input  op_type  op,
   input  logic    op_valid,
   output logic    clear_busy,
   output logic    full,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp
);

   localparam int WAW = $clog2(WORK_RAM_BYTES);
   localparam int PAW = $clog2(PATTERN_RAM_BYTES);

   logic [7:0] work_mem [WORK_RAM_BYTES];
   logic [7:0] pat_mem  [PATTERN_RAM_BYTES];

   // clearing pass over pattern ram after reset
   logic [PAW:0] clr_ff;
   assign clear_busy = !clr_ff[PAW];

   logic    s1_valid_ff, s1_rd_ff, s1_chr_ff;
   rsp_type s1_rsp_ff;
   logic [7:0] work_rd_ff, pat_rd_ff;

   // queue of four results
   rsp_type    q_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;
   rsp_type    s1_out;
   logic       push_q, pop_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (clear_busy) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_busy) begin
         pat_mem[clr_ff[PAW-1:0]] <= 8'd0;
      end else if (op.ram_wr && op.chr_ram) begin
         pat_mem[op.ram_index[PAW-1:0]] <= op.data;
      end
      pat_rd_ff <= pat_mem[op.ram_index[PAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (op.ram_wr && !op.chr_ram) begin
         work_mem[op.ram_index[WAW-1:0]] <= op.data;
      end
      work_rd_ff <= work_mem[op.ram_index[WAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= op_valid;
      end
      s1_rd_ff  <= op.ram_rd;
      s1_chr_ff <= op.chr_ram;
      s1_rsp_ff <= '{region: op.region, rom_address: op.rom_address, read_data: 8'd0,
                     mirroring: op.mirroring, irq_line: op.irq_line,
                     irq_raised: op.irq_raised};
   end

   always_comb begin
      s1_out = s1_rsp_ff;
      if (s1_rd_ff) s1_out.read_data = s1_chr_ff ? pat_rd_ff : work_rd_ff;
   end

   assign push_q = s1_valid_ff;
   assign pop_q  = pop && !empty;
   assign empty  = cnt_ff == 3'd0;
   // one slot held back for the transaction already in the ram stage
   assign full   = clear_busy || cnt_ff >= 3'd3 || (cnt_ff == 3'd2 && s1_valid_ff);
   assign rsp    = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push_q) wp_ff <= wp_ff + 2'd1;
         if (pop_q)  rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'b00, push_q} - {2'b00, pop_q};
      end
      if (push_q) q_ff[wp_ff] <= s1_out;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_q && !pop_q |-> cnt_ff < 3'd4)
      else $error("result queue overflow");
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !op_valid)
      else $error("transaction during clearing pass");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push_q && !pop_q |=> cnt_ff == $past(cnt_ff) + 3'd1)
      else $error("queue count mismatch");

endmodule

@@ src/bank_switch_mapper_irq_top.sv @@
// Bank switching mapper with scanline IRQ counter. One transaction (bus read,
// bus write or scanline clock) is taken per cycle while full is low; its
// result passes the registered internal RAM read and the result queue to the
// rsp_ side. A queue of four results lets the result side stall without
// stopping the request side until it fills. After reset the block clears its
// CHR-RAM, one byte a cycle, holding full high meanwhile.
// ----------------------------------------------------------------------------
// bank_switch_mapper_irq_top
// Top level: request front end, RAM back end and result queue.
// ----------------------------------------------------------------------------
module bank_switch_mapper_irq_top import bsm_pkg::*; #(
   parameter int WORK_RAM_BYTES    = 8192,
   parameter int PATTERN_RAM_BYTES = 8192
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  req_type    req_payload,
   output logic       empty,
   input  logic       pop,
   output rsp_type    rsp_payload,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [8:0] csr_data
);

   op_type op;
   logic   accept, clear_busy;

   assign accept    = push && !full;
   assign csr_ready = 1'b1;

   bsm_front #(
      .WORK_RAM_BYTES(WORK_RAM_BYTES), .PATTERN_RAM_BYTES(PATTERN_RAM_BYTES)
   ) u_front (
      .clock(clock), .reset(reset), .in_valid(accept), .in_req(req_payload),
      .cfg_we(csr_valid), .cfg_index(csr_index), .cfg_data(csr_data), .op(op)
   );

   bsm_back #(
      .WORK_RAM_BYTES(WORK_RAM_BYTES), .PATTERN_RAM_BYTES(PATTERN_RAM_BYTES)
   ) u_back (
      .clock(clock), .reset(reset), .op(op), .op_valid(accept),
      .clear_busy(clear_busy), .full(full), .empty(empty), .pop(pop), .rsp(rsp_payload)
   );

endmodule

@@ sim/tb_bank_switch_mapper_irq_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bank_switch_mapper_irq_top
// Drives bus reads, writes and scanline clocks into the mapper under several
// bank count settings, predicts every result and checks it field by field.
// ----------------------------------------------------------------------------
module tb_bank_switch_mapper_irq_top;
   import bsm_pkg::*;

   localparam int WORK_BYTES    = 8192;
   localparam int PATTERN_BYTES = 8192;
   localparam int STALL_LIMIT   = 40000;

   // mapper predictor and store of expected responses
   class mapper_scoreboard;
      int unsigned prg_count, chr_count;
      bit          mir_fixed;
      bit [2:0]    select_target;
      bit          prg_mode, chr_invert, mirror_mode, irq_enable, irq_pending;
      bit [7:0]    chr_regs[6];
      bit [5:0]    prg_regs[2];
      bit [7:0]    irq_latch, irq_count;
      bit [7:0]    work_ram[WORK_BYTES];
      bit [7:0]    pattern_ram[PATTERN_BYTES];
      rsp_type     expected_q[$];
      int          errors;

      function new();
         prg_count = 64;
         chr_count = 0;
         mir_fixed = 0;
         select_target = 0;
         prg_mode = 0;
         chr_invert = 0;
         mirror_mode = 0;
         irq_enable = 0;
         irq_pending = 0;
         irq_latch = 0;
         irq_count = 0;
         errors = 0;
         foreach (chr_regs[i]) chr_regs[i] = 0;
         foreach (prg_regs[i]) prg_regs[i] = 0;
         foreach (pattern_ram[i]) pattern_ram[i] = 0;
      endfunction

      function void set_csr(logic [1:0] idx, logic [8:0] val);
         case (idx)
            CSR_PRG_COUNT: prg_count = val[6:0];
            CSR_CHR_COUNT: chr_count = val;
            CSR_MIR_FIXED: mir_fixed = val[0];
            default: ;
         endcase
      endfunction

      function int unsigned chr_bank(bit [15:0] a);
         bit [2:0] slot;
         slot = a[12:10];
         if (chr_invert) slot ^= 3'd4;
         if (slot < 4) return chr_regs[slot >> 1] + slot[0];
         return chr_regs[slot - 2];
      endfunction

      function int unsigned prg_bank(bit [15:0] a);
         bit [5:0] mask, second_last, bank;
         mask = 6'(prg_count - 1);
         second_last = 6'(prg_count - 2);
         case (a[14:13])
            2'd0: bank = prg_mode ? second_last : prg_regs[0];
            2'd1: bank = prg_regs[1];
            2'd2: bank = prg_mode ? prg_regs[0] : second_last;
            default: bank = mask;
         endcase
         return bank & mask;
      endfunction

      function void program_reg(bit [15:0] a, bit [7:0] d);
         if (a < 16'hA000) begin
            if (!a[0]) begin
               select_target = d[2:0];
               prg_mode = d[6];
               chr_invert = d[7];
            end else if (select_target < 2) begin
               chr_regs[select_target] = d & 8'hFE;
            end else if (select_target < 6) begin
               chr_regs[select_target] = d;
            end else begin
               prg_regs[select_target - 6] = d[5:0];
            end
         end else if (a < 16'hC000) begin
            if (!a[0] && !mir_fixed) mirror_mode = d[0];
         end else if (a < 16'hE000) begin
            if (!a[0]) irq_latch = d;
            else irq_count = 0;
         end else begin
            if (!a[0]) begin
               irq_enable = 0;
               irq_pending = 0;
            end else begin
               irq_enable = 1;
            end
         end
      endfunction

      function void note_request(req_type r);
         rsp_type     e;
         int unsigned adr;
         e = '0;
         if (r.action == ACT_READ || r.action == ACT_WRITE) begin
            if (r.addr < 16'h2000) begin
               adr = chr_bank(r.addr) * 32'h400 + r.addr[9:0];
               if (chr_count != 0) begin
                  e.region = REG_CHR_ROM;
                  e.rom_address = 19'((chr_bank(r.addr) & (chr_count - 1)) * 32'h400
                                      + r.addr[9:0]);
               end else begin
                  e.region = REG_CHR_RAM;
                  e.rom_address = 19'(adr % PATTERN_BYTES);
                  if (r.action == ACT_READ) e.read_data = pattern_ram[adr % PATTERN_BYTES];
                  else pattern_ram[adr % PATTERN_BYTES] = r.data;
               end
            end else if (r.addr >= 16'h6000 && r.addr < 16'h8000) begin
               adr = (r.addr - 16'h6000) % WORK_BYTES;
               e.region = REG_PRG_RAM;
               e.rom_address = 19'(adr);
               if (r.action == ACT_READ) e.read_data = work_ram[adr];
               else work_ram[adr] = r.data;
            end else if (r.addr >= 16'h8000) begin
               e.region = REG_PRG_ROM;
               e.rom_address = 19'(prg_bank(r.addr) * 32'h2000 + r.addr[12:0]);
               if (r.action == ACT_WRITE) program_reg(r.addr, r.data);
            end
         end else if (r.action == ACT_CLOCK) begin
            if (irq_count == 0) irq_count = irq_latch;
            else irq_count = irq_count - 1;
            if (irq_count == 0 && irq_enable) begin
               irq_pending = 1;
               e.irq_raised = 1;
            end
         end
         e.mirroring = mirror_mode;
         e.irq_line = irq_pending;
         expected_q.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected response %h", got);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (got.region !== e.region) begin
            $error("region exp %0d got %0d", e.region, got.region); errors++;
         end
         if (got.rom_address !== e.rom_address) begin
            $error("rom_address exp %h got %h", e.rom_address, got.rom_address); errors++;
         end
         if (got.read_data !== e.read_data) begin
            $error("read_data exp %h got %h", e.read_data, got.read_data); errors++;
         end
         if (got.mirroring !== e.mirroring) begin
            $error("mirroring exp %0d got %0d", e.mirroring, got.mirroring); errors++;
         end
         if (got.irq_line !== e.irq_line) begin
            $error("irq_line exp %0d got %0d", e.irq_line, got.irq_line); errors++;
         end
         if (got.irq_raised !== e.irq_raised) begin
            $error("irq_raised exp %0d got %0d", e.irq_raised, got.irq_raised); errors++;
         end
      endfunction
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       push = 0;
   logic       full;
   req_type    req_payload = '0;
   logic       empty;
   logic       pop = 0;
   rsp_type    rsp_payload;
   logic       csr_valid = 0;
   logic       csr_ready;
   logic [1:0] csr_index = '0;
   logic [8:0] csr_data = '0;

   mapper_scoreboard sb;
   int  push_idle_pct, pop_idle_pct;
   int  quiet_cycles = 0;
   int  items_sent;
   bit  written[WORK_BYTES];

   always #5 clock = ~clock;

   bank_switch_mapper_irq_top #(
      .WORK_RAM_BYTES   (WORK_BYTES),
      .PATTERN_RAM_BYTES(PATTERN_BYTES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_payload(req_payload),
      .empty      (empty),
      .pop        (pop),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // response side: random stall, check at the rising edge
   always @(posedge clock) begin
      if (!reset && pop && !empty) sb.check_response(rsp_payload);
   end
   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= pop_idle_pct);
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog expired");
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // push stays high after a transaction so requests can go back to back
   task automatic send_request(action_type act, logic [15:0] a, logic [7:0] d);
      req_type r;
      // never read work RAM bytes that were not written
      if (act == ACT_READ && a >= 16'h6000 && a < 16'h8000 && !written[a - 16'h6000])
         act = ACT_WRITE;
      if (act == ACT_WRITE && a >= 16'h6000 && a < 16'h8000) written[a - 16'h6000] = 1;
      r.action = act;
      r.addr = a;
      r.data = d;
      while ($urandom_range(99) < push_idle_pct) begin
         push <= 0;
         @(negedge clock);
      end
      push <= 1;
      req_payload <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      sb.note_request(r);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      push <= 0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [8:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_csr(idx, val);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   // mostly register programming and well-formed accesses
   task automatic random_burst(int count);
      int k;
      logic [15:0] a;
      for (k = 0; k < count; k++) begin
         case ($urandom_range(9))
            0, 1: send_request(ACT_WRITE, 16'(16'h8000 | ($urandom_range(7) << 13)
                               | $urandom_range(1)), 8'($urandom_range(255)));
            2:    send_request(ACT_WRITE, 16'($urandom), 8'($urandom_range(255)));
            3, 4: send_request(ACT_CLOCK, 16'($urandom), 8'($urandom_range(255)));
            5:    send_request(ACT_WRITE, 16'(16'h6000 + $urandom_range(8191)),
                               8'($urandom_range(255)));
            6:    send_request(ACT_READ, 16'(16'h6000 + $urandom_range(8191)),
                               8'($urandom_range(255)));
            7:    send_request(action_type'($urandom_range(3)), 16'($urandom), 8'($urandom));
            default: begin
               a = 16'($urandom_range(16'h1FFF));
               send_request(action_type'($urandom_range(1)), a, 8'($urandom_range(255)));
            end
         endcase
      end
   endtask

   task automatic run_phase(int count);
      push_idle_pct = 35; pop_idle_pct = 77;
      random_burst(count / 3);
      push_idle_pct = 77; pop_idle_pct = 35;
      random_burst(count / 3);
      push_idle_pct = 0; pop_idle_pct = 0;
      random_burst(count / 3);
      drain();
   endtask

   initial begin
      sb = new();
      push_idle_pct = 0;
      pop_idle_pct = 0;
      items_sent = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: bank regs, IRQ, mirroring, extremes, unmapped, no-op action
      send_request(ACT_READ, 16'h0000, 8'h00);
      send_request(ACT_WRITE, 16'h1FFF, 8'hFF);
      send_request(ACT_READ, 16'h1FFF, 8'h00);
      send_request(ACT_READ, 16'h3000, 8'h00);
      send_request(ACT_WRITE, 16'h6000, 8'hA5);
      send_request(ACT_WRITE, 16'h7FFF, 8'h5A);
      send_request(ACT_READ, 16'h7FFF, 8'h00);
      send_request(ACT_WRITE, 16'h8000, 8'hC6);
      send_request(ACT_WRITE, 16'h8001, 8'hFF);
      send_request(ACT_WRITE, 16'h8000, 8'h07);
      send_request(ACT_WRITE, 16'h9FFF, 8'h3F);
      send_request(ACT_READ, 16'hFFFF, 8'h00);
      send_request(ACT_READ, 16'h8000, 8'h00);
      send_request(ACT_WRITE, 16'hA000, 8'h01);
      send_request(ACT_WRITE, 16'hA001, 8'h00);
      send_request(ACT_WRITE, 16'hC000, 8'h02);
      send_request(ACT_WRITE, 16'hC001, 8'h00);
      send_request(ACT_WRITE, 16'hE001, 8'h00);
      repeat (4) send_request(ACT_CLOCK, 16'h0000, 8'h00);
      send_request(ACT_WRITE, 16'hE000, 8'h00);
      send_request(ACT_NONE, 16'hFFFF, 8'hFF);
      drain();

      run_phase(300);
      write_csr(CSR_PRG_COUNT, 9'd2);
      write_csr(CSR_CHR_COUNT, 9'd256);
      write_csr(CSR_MIR_FIXED, 9'd1);
      run_phase(300);
      write_csr(CSR_PRG_COUNT, 9'd0);
      write_csr(CSR_CHR_COUNT, 9'd1);
      run_phase(300);
      write_csr(CSR_PRG_COUNT, 9'd1);
      write_csr(CSR_CHR_COUNT, 9'd8);
      write_csr(CSR_MIR_FIXED, 9'd0);
      write_csr(2'd3, 9'h1FF);
      run_phase(300);
      write_csr(CSR_PRG_COUNT, 9'd64);
      write_csr(CSR_CHR_COUNT, 9'd0);
      run_phase(450);

      $display("covered %0d transactions over five bank count settings", items_sent);
      $display("including fixed mirroring, CHR-RAM and tiny bank counts");
      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
